// ===== hw/rtl/qspe_pkg.sv =====
`timescale 1ns / 1ps

package qspe_pkg;

    // Field and register widths.
    localparam int DELTA_W  = 16;
    localparam int VAL_W    = 48;
    localparam int COUNT_W  = 32;
    localparam int PPR_W    = 16;
    localparam int PERIOD_W = 20;
    localparam int CIDX_W   = 4;
    localparam int CDATA_W  = 20;
    localparam int DEN_W    = PPR_W + PERIOD_W;
    localparam int NUM_W    = 64;
    localparam int MUL_W    = 33;
    localparam int PROD_W   = 64;

    // Register indexes on the configuration port.
    localparam logic [CIDX_W-1:0] CFG_PPR    = 4'd0;
    localparam logic [CIDX_W-1:0] CFG_PERIOD = 4'd1;

    localparam logic [PPR_W-1:0]    PPR_RESET    = 16'd1024;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd1000;

    // 60e6 us/min * 256 (Q8) / 4 (x4 decoding).
    localparam logic [31:0] SPEED_SCALE = 32'd3840000000;
    // 360 degrees * 256 (Q8) / 4 (x4 decoding).
    localparam logic [15:0] ANGLE_SCALE = 16'd23040;
    // Filter coefficients in Q0.16: 0.854 and 0.0728.
    localparam logic [15:0] COEF_A = 16'd55968;
    localparam logic [15:0] COEF_B = 16'd4771;
    localparam logic [63:0] ROUND_HALF = 64'd32768;

    localparam logic [VAL_W-1:0] VAL_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [VAL_W-1:0] VAL_MIN = 48'h8000_0000_0000;

    typedef enum logic [1:0] {
        OP_SAMPLE   = 2'd0,
        OP_POSITION = 2'd1,
        OP_RESET    = 2'd2,
        OP_FILTERED = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MODE_X4   = 2'd0,
        MODE_X1   = 2'd1,
        MODE_DEG  = 2'd2,
        MODE_ZERO = 2'd3
    } cmode_t;

    // Divider result: sat is set when the quotient is 2^48 or more, or the divisor is zero.
    typedef struct packed {
        logic             sat;
        logic [VAL_W-1:0] quot;
    } div_res_t;

endpackage

// ===== hw/rtl/qspe_mul.sv =====
`timescale 1ns / 1ps

module qspe_mul (
    input  logic                                clk,
    input  logic signed [qspe_pkg::MUL_W-1:0]   a,
    input  logic signed [qspe_pkg::MUL_W-1:0]   b,
    output logic signed [qspe_pkg::PROD_W-1:0]  p
);
    import qspe_pkg::*;

    logic signed [2*MUL_W-1:0] prod;
    logic signed [PROD_W-1:0]  p_reg;

    // Every use keeps its product inside 64 bits, so the top bits are dropped.
    assign prod = a * b;

    always_ff @(posedge clk)
    begin
        p_reg <= prod[PROD_W-1:0];
    end

    assign p = p_reg;

endmodule

// ===== hw/rtl/qspe_div.sv =====
`timescale 1ns / 1ps

module qspe_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [qspe_pkg::NUM_W-1:0]        num,
    input  logic [qspe_pkg::DEN_W-1:0]        den,
    output logic                              done,
    output qspe_pkg::div_res_t                res
);
    import qspe_pkg::*;

    localparam int CNT_W = $clog2(VAL_W);
    localparam int HI_W  = NUM_W - VAL_W;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic               sat_reg, sat_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DEN_W:0]     rem_reg, rem_next;
    logic [VAL_W-1:0]   q_reg, q_next;
    logic [DEN_W-1:0]   den_reg, den_next;
    logic [NUM_W-1:0]   biased;
    logic [DEN_W:0]     shifted;
    logic [DEN_W:0]     diff;

    // Rounding to nearest: add half the divisor before dividing.
    assign biased  = num + {{(NUM_W-DEN_W+1){1'b0}}, den[DEN_W-1:1]};
    assign shifted = {rem_reg[DEN_W-1:0], q_reg[VAL_W-1]};
    assign diff    = shifted - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        sat_next  = sat_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        if (start)
        begin
            den_next = den;
            // A high part at or above the divisor means a quotient of 2^48 or more.
            if ({{(DEN_W+1-HI_W){1'b0}}, biased[NUM_W-1:VAL_W]} >= {1'b0, den})
            begin
                sat_next  = 1'b1;
                done_next = 1'b1;
                q_next    = '0;
            end
            else
            begin
                sat_next  = 1'b0;
                busy_next = 1'b1;
                rem_next  = {{(DEN_W+1-HI_W){1'b0}}, biased[NUM_W-1:VAL_W]};
                q_next    = biased[VAL_W-1:0];
                cnt_next  = CNT_W'(VAL_W - 1);
            end
        end
        else if (busy_reg)
        begin
            if (!diff[DEN_W])
            begin
                rem_next = diff;
                q_next   = {q_reg[VAL_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                q_next   = {q_reg[VAL_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sat_reg <= sat_next;
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign res.sat  = sat_reg;
    assign res.quot = q_reg;

endmodule

// ===== hw/rtl/quadrature_speed_position_estimator_core.sv =====
`timescale 1ns / 1ps

// Quadrature encoder speed and position estimator.
// Input items arrive on the s_axis channel: tdata carries the signed x4 count
// delta read from the timer, tuser carries the operation and the position mode.
// Results leave on the m_axis channel as signed Q39.8 values in tdata. A
// sample_speed, read_position or read_filtered item gives one result; a reset
// item clears the count, the previous count and the previous speed, gives
// none and leaves the block ready on the very next cycle.
// The block handles one item at a time and drops s_axis_tready until the item
// is finished. A sample_speed item uses two products on the shared 33x33
// multiplier, a 48-step restoring divide for the rounded speed, six multiplier
// passes for the IIR filter and a rounding step in S_FRND and S_FOUT; an angle
// read uses the two products and the divide. A zero divisor or a quotient that
// overflows skips the divide steps. x4, x1 and zero reads pass through S_PREP,
// a filtered read goes straight to S_EMIT; the input is ready again in the
// cycle the result appears. While the receiver stalls the next item may be
// accepted and worked on, but no new result is loaded until the held one is
// taken. The user must write registers on the always-ready cfg channel only
// while idle; the block does not enforce it. Reset sets 1024 lines, 1000 us.
module quadrature_speed_position_estimator_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [15:0]                         s_axis_tdata,  // [15:0] timer_delta
    input  logic [3:0]                          s_axis_tuser,  // [1:0] operation, [3:2] pos_mode
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [47:0]                         m_axis_tdata,  // [47:0] value
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [qspe_pkg::CIDX_W-1:0]         cfg_index,
    input  logic [qspe_pkg::CDATA_W-1:0]        cfg_data
);
    import qspe_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_NUM,
        S_DEN,
        S_DIV_START,
        S_DIV_WAIT,
        S_FILT,
        S_FRND,
        S_FOUT,
        S_EMIT
    } state_t;

    state_t                 state_reg, state_next;
    op_t                    op_reg, op_next;
    cmode_t                 mode_reg, mode_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [COUNT_W-1:0]     prev_count_reg, prev_count_next;
    logic [VAL_W-1:0]       prev_speed_reg, prev_speed_next;
    logic [VAL_W-1:0]       filt_reg, filt_next;
    logic [PPR_W-1:0]       ppr_reg, ppr_next;
    logic [PERIOD_W-1:0]    period_reg, period_next;
    logic                   neg_reg, neg_next;
    logic [COUNT_W-1:0]     abs_reg, abs_next;
    logic [NUM_W-1:0]       num_reg, num_next;
    logic [VAL_W-1:0]       raw_reg, raw_next;
    logic [VAL_W-1:0]       res_reg, res_next;
    logic signed [PROD_W-1:0] acc_reg, acc_next;
    logic [PROD_W-1:0]      fmag_reg, fmag_next;
    logic [2:0]             fcnt_reg, fcnt_next;
    logic                   out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]       out_data_reg, out_data_next;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic                     div_start;
    logic                     div_done;
    div_res_t                 div_res;

    logic [COUNT_W-1:0]     delta_ext;
    logic [COUNT_W-1:0]     diff;
    logic [COUNT_W-1:0]     mag_src;
    logic [VAL_W-1:0]       fsel;
    logic [15:0]            fcoef;
    logic signed [PROD_W-1:0] addend;
    logic [PROD_W-1:0]      fsum;
    logic [VAL_W-1:0]       div_val;

    // Saturating sign application for a rounded magnitude.
    function automatic logic [VAL_W-1:0] fmt_val(input logic neg, input logic sat,
                                                 input logic [VAL_W-1:0] q);
        logic [VAL_W-1:0] r;
        if (sat || q[VAL_W-1])
            r = neg ? VAL_MIN : VAL_MAX;
        else
            r = neg ? (VAL_W'(0) - q) : q;
        return r;
    endfunction

    qspe_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    qspe_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (mul_p[DEN_W-1:0]),
        .done  (div_done),
        .res   (div_res)
    );

    assign delta_ext = {{(COUNT_W-DELTA_W){s_axis_tdata[DELTA_W-1]}}, s_axis_tdata};
    assign diff      = count_reg - prev_count_reg;
    assign mag_src   = (op_reg == OP_SAMPLE) ? diff : count_reg;

    // Filter terms: a*filtered, b*raw, b*previous; each split into a low
    // unsigned 32-bit half and a high signed 16-bit half.
    always_comb
    begin
        case (fcnt_reg[2:1])
            2'd0:    fsel = filt_reg;
            2'd1:    fsel = raw_reg;
            2'd2:    fsel = prev_speed_reg;
            default: fsel = '0;
        endcase
    end

    assign fcoef  = (fcnt_reg[2:1] == 2'd0) ? COEF_A : COEF_B;
    // An even step count means the product now out of the multiplier is a high half.
    assign addend = fcnt_reg[0] ? mul_p : (mul_p <<< 32);
    assign fsum   = fmag_reg + ROUND_HALF;
    assign div_val = (num_reg == '0) ? '0 : fmt_val(neg_reg, div_res.sat, div_res.quot);

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        mode_next       = mode_reg;
        count_next      = count_reg;
        prev_count_next = prev_count_reg;
        prev_speed_next = prev_speed_reg;
        filt_next       = filt_reg;
        ppr_next        = ppr_reg;
        period_next     = period_reg;
        neg_next        = neg_reg;
        abs_next        = abs_reg;
        num_next        = num_reg;
        raw_next        = raw_reg;
        res_next        = res_reg;
        acc_next        = acc_reg;
        fmag_next       = fmag_reg;
        fcnt_next       = fcnt_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_data_next   = out_data_reg;
        mul_a           = '0;
        mul_b           = '0;
        div_start       = 1'b0;

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PPR:    ppr_next    = cfg_data[PPR_W-1:0];
                CFG_PERIOD: period_next = cfg_data[PERIOD_W-1:0];
                default:    ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next   = op_t'(s_axis_tuser[1:0]);
                    mode_next = cmode_t'(s_axis_tuser[3:2]);
                    case (op_t'(s_axis_tuser[1:0]))
                        OP_RESET:
                        begin
                            count_next      = '0;
                            prev_count_next = '0;
                            prev_speed_next = '0;
                        end
                        OP_FILTERED:
                        begin
                            res_next   = filt_reg;
                            state_next = S_EMIT;
                        end
                        default:
                        begin
                            count_next = count_reg + delta_ext;
                            state_next = S_PREP;
                        end
                    endcase
                end
            end
            S_PREP:
            begin
                neg_next = mag_src[COUNT_W-1];
                abs_next = mag_src[COUNT_W-1] ? (COUNT_W'(0) - mag_src) : mag_src;
                if (op_reg == OP_SAMPLE)
                    state_next = S_NUM;
                else
                begin
                    case (mode_reg)
                        MODE_X4:
                        begin
                            res_next   = {{(VAL_W-COUNT_W-8){count_reg[COUNT_W-1]}},
                                          count_reg, 8'd0};
                            state_next = S_EMIT;
                        end
                        MODE_X1:
                        begin
                            res_next   = {{(VAL_W-COUNT_W-6){count_reg[COUNT_W-1]}},
                                          count_reg, 6'd0};
                            state_next = S_EMIT;
                        end
                        MODE_DEG:
                            state_next = S_NUM;
                        default:
                        begin
                            res_next   = '0;
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_NUM:
            begin
                mul_a = {1'b0, abs_reg};
                if (op_reg == OP_SAMPLE)
                    mul_b = {1'b0, SPEED_SCALE};
                else
                    mul_b = {17'd0, ANGLE_SCALE};
                state_next = S_DEN;
            end
            S_DEN:
            begin
                num_next = mul_p;
                if (op_reg == OP_SAMPLE)
                begin
                    mul_a = {13'd0, period_reg};
                    mul_b = {17'd0, ppr_reg};
                end
                else
                begin
                    mul_a = {17'd0, ppr_reg};
                    mul_b = MUL_W'(1);
                end
                state_next = S_DIV_START;
            end
            S_DIV_START:
            begin
                div_start  = 1'b1;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    if (op_reg == OP_SAMPLE)
                    begin
                        raw_next   = div_val;
                        fcnt_next  = '0;
                        state_next = S_FILT;
                    end
                    else
                    begin
                        res_next   = div_val;
                        state_next = S_EMIT;
                    end
                end
            end
            S_FILT:
            begin
                // Issue product k, accumulate product k-1.
                if (fcnt_reg != 3'd6)
                begin
                    if (fcnt_reg[0])
                        mul_a = {{(MUL_W-16){fsel[VAL_W-1]}}, fsel[VAL_W-1:32]};
                    else
                        mul_a = {1'b0, fsel[31:0]};
                    mul_b = {17'd0, fcoef};
                end
                if (fcnt_reg == 3'd0)
                    acc_next = '0;
                else
                    acc_next = acc_reg + addend;
                fcnt_next = fcnt_reg + 1'b1;
                if (fcnt_reg == 3'd6)
                    state_next = S_FRND;
            end
            S_FRND:
            begin
                neg_next   = acc_reg[PROD_W-1];
                fmag_next  = acc_reg[PROD_W-1] ? (PROD_W'(0) - acc_reg) : acc_reg;
                state_next = S_FOUT;
            end
            S_FOUT:
            begin
                filt_next       = fmt_val(neg_reg, 1'b0, fsum[PROD_W-1:16]);
                prev_speed_next = raw_reg;
                prev_count_next = count_reg;
                res_next        = raw_reg;
                state_next      = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            prev_count_reg <= '0;
            prev_speed_reg <= '0;
            filt_reg       <= '0;
            ppr_reg        <= PPR_RESET;
            period_reg     <= PERIOD_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            prev_count_reg <= prev_count_next;
            prev_speed_reg <= prev_speed_next;
            filt_reg       <= filt_next;
            ppr_reg        <= ppr_next;
            period_reg     <= period_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        mode_reg     <= mode_next;
        neg_reg      <= neg_next;
        abs_reg      <= abs_next;
        num_reg      <= num_next;
        raw_reg      <= raw_next;
        res_reg      <= res_next;
        acc_reg      <= acc_next;
        fmag_reg     <= fmag_next;
        fcnt_reg     <= fcnt_next;
        out_data_reg <= out_data_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign cfg_ready     = 1'b1;

endmodule

// ===== hw/rtl/qspe_chk.sv =====
`timescale 1ns / 1ps

module qspe_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [3:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);
    import qspe_pkg::*;

    logic in_acc;

    assign in_acc = s_axis_tvalid && s_axis_tready;

    // Any item other than a reset drops the input ready once it is accepted.
    a_busy_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (s_axis_tuser[1:0] != OP_RESET) |=> !s_axis_tready)
        else $error("input still ready after accepting a working item");

    // A reset item finishes at once.
    a_reset_quick: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (s_axis_tuser[1:0] == OP_RESET) |=> s_axis_tready)
        else $error("block not ready after a reset item");

    // A result held by the receiver stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed or dropped");

    // A new result only appears while an item is being worked on.
    a_out_from_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared while the block was idle");

endmodule

bind quadrature_speed_position_estimator_core qspe_chk u_qspe_chk (.*);
